@@ sv/lsrq_pkg.sv @@
// Package for the level-sorted run queue: word types, actions, controller states.
// Used by lsrq_ctrl, lsrq_dp, level_sorted_run_queue and the checker.
package lsrq_pkg;
  localparam int MaxTasks = 16;
  localparam int IdW = 4;
  localparam int CntW = 5;

  // Slot flag codes.
  localparam logic [1:0] FlagUnused = 2'd0;
  localparam logic [1:0] FlagUsed = 2'd1;
  localparam logic [1:0] FlagActive = 2'd2;

  typedef enum logic [1:0] {
    ACT_ALLOC = 2'd0,
    ACT_ACTIVATE = 2'd1,
    ACT_DEACT = 2'd2,
    ACT_SWITCH = 2'd3
  } action_t;

  typedef enum logic [0:0] {
    CFG_DEF_PRIO = 1'b0,
    CFG_DEF_LEVEL = 1'b1
  } cfg_idx_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_DECODE,
    ST_ALLOC,
    ST_FIND,
    ST_INS_SCAN,
    ST_INS_SHIFT,
    ST_MOVE_UP,
    ST_MOVE_DN,
    ST_DEL_SHIFT,
    ST_FIX,
    ST_DONE
  } state_t;

  typedef struct packed {
    logic [1:0] action;
    logic [3:0] task_id;
    logic [7:0] req_prio;
    logic [3:0] req_level;
  } in_word_t;

  typedef struct packed {
    logic [3:0] allocated_id;
    logic ok;
    logic switched;
    logic [3:0] current_task;
    logic [7:0] current_priority;
    logic [4:0] running_count;
  } out_word_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic load;        // capture input word, apply priority/level update
    logic clr_idx;     // idx <= 0
    logic inc_idx;
    logic set_idx_len; // idx <= run_length
    logic alloc_take;  // claim slot idx
    logic ins_put;     // write slot at idx, run_length++, flag active
    logic shift_up;    // order[idx] <= order[idx-1], idx--
    logic shift_dn;    // order[idx] <= order[idx+1], idx++
    logic put_slot;    // order[idx] <= slot
    logic del_shift;   // order[idx] <= order[idx+1], idx++
    logic del_done;    // run_length--, cursor fix for removal
    logic mark_used;
    logic set_cursor;  // cursor <= idx
    logic do_switch;
    logic set_ok;
  } cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    action_t action;
    logic in_range;
    logic is_active;
    logic full;
    logic dir_up;
    logic dir_dn;
    logic idx_end;       // idx >= run_length
    logic idx_last;      // idx + 1 >= run_length
    logic idx_zero;
    logic flag_unused;   // slot_flag[idx] unused
    logic idx_all;       // idx reached MaxTasks-1
    logic order_hit;     // order[idx] == slot
    logic run_hit;       // order[idx] == running_task
    logic up_go;         // level > level of order[idx-1]
    logic dn_go;         // level < level of order[idx+1]
  } sts_t;
endpackage

@@ sv/lsrq_ctrl.sv @@
// Controller state machine of the run queue: sequences one word's action.
// Depends on lsrq_pkg.
module lsrq_ctrl (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_ready,
  output logic              out_valid,
  input  logic              out_ready,
  input  lsrq_pkg::sts_t    sts,
  output lsrq_pkg::cmd_t    cmd
);
  lsrq_pkg::state_t state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= lsrq_pkg::ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      lsrq_pkg::ST_IDLE: if (in_valid) state_nxt = lsrq_pkg::ST_DECODE;
      lsrq_pkg::ST_DECODE: begin
        unique case (sts.action)
          lsrq_pkg::ACT_ALLOC: state_nxt = lsrq_pkg::ST_ALLOC;
          lsrq_pkg::ACT_ACTIVATE: begin
            if (!sts.in_range) state_nxt = lsrq_pkg::ST_DONE;
            else if (sts.is_active) begin
              if (sts.dir_up || sts.dir_dn) state_nxt = lsrq_pkg::ST_FIND;
              else state_nxt = lsrq_pkg::ST_DONE;
            end else if (sts.full) state_nxt = lsrq_pkg::ST_DONE;
            else state_nxt = lsrq_pkg::ST_INS_SCAN;
          end
          lsrq_pkg::ACT_DEACT:
            state_nxt = sts.in_range ? lsrq_pkg::ST_FIND : lsrq_pkg::ST_DONE;
          default: state_nxt = lsrq_pkg::ST_DONE;
        endcase
      end
      lsrq_pkg::ST_ALLOC:
        if (sts.flag_unused || sts.idx_all) state_nxt = lsrq_pkg::ST_DONE;
      lsrq_pkg::ST_FIND: begin
        if (sts.idx_end) state_nxt = lsrq_pkg::ST_DONE;
        else if (sts.order_hit) begin
          if (sts.action == lsrq_pkg::ACT_DEACT) state_nxt = lsrq_pkg::ST_DEL_SHIFT;
          else if (sts.dir_up) state_nxt = lsrq_pkg::ST_MOVE_UP;
          else state_nxt = lsrq_pkg::ST_MOVE_DN;
        end
      end
      lsrq_pkg::ST_INS_SCAN:
        if (sts.idx_zero || !sts.up_go) state_nxt = lsrq_pkg::ST_INS_SHIFT;
      lsrq_pkg::ST_INS_SHIFT: state_nxt = lsrq_pkg::ST_DONE;
      lsrq_pkg::ST_MOVE_UP:
        if (sts.idx_zero || !sts.up_go) state_nxt = lsrq_pkg::ST_FIX;
      lsrq_pkg::ST_MOVE_DN:
        if (sts.idx_last || !sts.dn_go) state_nxt = lsrq_pkg::ST_FIX;
      lsrq_pkg::ST_DEL_SHIFT: if (sts.idx_last) state_nxt = lsrq_pkg::ST_DONE;
      lsrq_pkg::ST_FIX:
        if (sts.idx_end || sts.run_hit) state_nxt = lsrq_pkg::ST_DONE;
      lsrq_pkg::ST_DONE: if (out_ready) state_nxt = lsrq_pkg::ST_IDLE;
      default: state_nxt = lsrq_pkg::ST_IDLE;
    endcase
  end

  // Insert is done with a counter walking down from run_length; the scan
  // stage shifts entries until the insert point is reached.
  always_comb begin
    cmd = '0;
    in_ready = 1'b0;
    out_valid = 1'b0;
    unique case (state_r)
      lsrq_pkg::ST_IDLE: begin
        in_ready = 1'b1;
        cmd.load = in_valid;
        cmd.clr_idx = 1'b1;
      end
      lsrq_pkg::ST_DECODE: begin
        if (sts.action == lsrq_pkg::ACT_SWITCH) cmd.do_switch = 1'b1;
        if (sts.action == lsrq_pkg::ACT_DEACT && sts.in_range) cmd.mark_used = 1'b1;
        if (sts.action == lsrq_pkg::ACT_ACTIVATE && sts.in_range &&
            (sts.is_active || !sts.full)) cmd.set_ok = 1'b1;
        if (sts.action == lsrq_pkg::ACT_ACTIVATE && sts.in_range &&
            !sts.is_active && !sts.full) cmd.set_idx_len = 1'b1;
      end
      lsrq_pkg::ST_ALLOC: begin
        if (sts.flag_unused) cmd.alloc_take = 1'b1;
        else if (!sts.idx_all) cmd.inc_idx = 1'b1;
      end
      lsrq_pkg::ST_FIND: if (!sts.idx_end && !sts.order_hit) cmd.inc_idx = 1'b1;
      lsrq_pkg::ST_INS_SCAN: begin
        // idx walks down from run_length; shift while the slot goes above.
        if (!(sts.idx_zero || !sts.up_go)) cmd.shift_up = 1'b1;
      end
      lsrq_pkg::ST_INS_SHIFT: cmd.ins_put = 1'b1;
      lsrq_pkg::ST_MOVE_UP: begin
        if (sts.idx_zero || !sts.up_go) begin
          cmd.put_slot = 1'b1;
          cmd.clr_idx = 1'b1;
        end else cmd.shift_up = 1'b1;
      end
      lsrq_pkg::ST_MOVE_DN: begin
        if (sts.idx_last || !sts.dn_go) begin
          cmd.put_slot = 1'b1;
          cmd.clr_idx = 1'b1;
        end else cmd.shift_dn = 1'b1;
      end
      lsrq_pkg::ST_DEL_SHIFT: begin
        if (sts.idx_last) cmd.del_done = 1'b1;
        else cmd.del_shift = 1'b1;
      end
      lsrq_pkg::ST_FIX: begin
        if (!sts.idx_end) begin
          if (sts.run_hit) cmd.set_cursor = 1'b1;
          else cmd.inc_idx = 1'b1;
        end
      end
      lsrq_pkg::ST_DONE: out_valid = 1'b1;
      default: ;
    endcase
  end
endmodule

@@ sv/lsrq_dp.sv @@
// Datapath of the run queue: slot table, ordered run list, cursor, result word.
// Depends on lsrq_pkg.
module lsrq_dp (
  input  logic                clk,
  input  logic                rst_n,
  input  lsrq_pkg::in_word_t  in_word,
  input  logic                cfg_we,
  input  logic [0:0]          cfg_sel,
  input  logic                cfg_hit,
  input  logic [7:0]          cfg_wdata,
  input  lsrq_pkg::cmd_t      cmd,
  output lsrq_pkg::sts_t      sts,
  output lsrq_pkg::out_word_t out_word
);
  localparam int N = lsrq_pkg::MaxTasks;
  localparam int IW = lsrq_pkg::IdW;
  localparam int CW = lsrq_pkg::CntW;

  logic [1:0]    flag_r  [N];
  logic [3:0]    level_r [N];
  logic [7:0]    prio_r  [N];
  logic [IW-1:0] order_r [N];
  logic [CW-1:0] len_r;
  logic [IW-1:0] cursor_r, run_r, idx_r, slot_r;
  lsrq_pkg::action_t act_r;
  logic [3:0] lvl_r;
  logic up_r, dn_r, ok_r, sw_r, range_r;
  logic [IW-1:0] alloc_r;
  logic [7:0] def_prio_r;
  logic [3:0] def_lvl_r;
  // Position where a removed slot was found; the shift walk starts there.
  logic [IW-1:0] slot_pos_r;

  logic [IW-1:0] idx_m1, idx_p1;
  logic [CW-1:0] idx_w;
  logic [IW-1:0] nxt_cur;
  assign idx_m1 = idx_r - IW'(1);
  assign idx_p1 = idx_r + IW'(1);
  assign idx_w = {1'b0, idx_r};

  always_comb begin
    sts.action = act_r;
    sts.in_range = range_r;
    sts.is_active = flag_r[slot_r] == lsrq_pkg::FlagActive;
    sts.full = len_r >= CW'(N);
    sts.dir_up = up_r;
    sts.dir_dn = dn_r;
    sts.idx_end = idx_w >= len_r;
    sts.idx_last = (idx_w + CW'(1)) >= len_r;
    sts.idx_zero = idx_r == '0;
    sts.flag_unused = flag_r[idx_r] == lsrq_pkg::FlagUnused;
    sts.idx_all = idx_r == IW'(N - 1);
    sts.order_hit = order_r[idx_r] == slot_r;
    sts.run_hit = order_r[idx_r] == run_r;
    sts.up_go = lvl_r > level_r[order_r[idx_m1]];
    sts.dn_go = lvl_r < level_r[order_r[idx_p1]];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < N; i++) begin
        flag_r[i] <= lsrq_pkg::FlagUnused;
        level_r[i] <= 4'd0;
        prio_r[i] <= 8'd0;
        order_r[i] <= '0;
      end
      flag_r[0] <= lsrq_pkg::FlagActive;
      level_r[0] <= 4'd4;
      prio_r[0] <= 8'd3;
      len_r <= CW'(1);
      cursor_r <= '0;
      run_r <= '0;
      idx_r <= '0;
      def_prio_r <= 8'd2;
      def_lvl_r <= 4'd2;
      ok_r <= 1'b0;
      sw_r <= 1'b0;
      alloc_r <= '0;
      up_r <= 1'b0;
      dn_r <= 1'b0;
      range_r <= 1'b0;
      slot_r <= '0;
      lvl_r <= '0;
      act_r <= lsrq_pkg::ACT_ALLOC;
    end else begin
      if (cfg_we && cfg_hit) begin
        if (cfg_sel == lsrq_pkg::CFG_DEF_PRIO) def_prio_r <= cfg_wdata;
        else def_lvl_r <= cfg_wdata[3:0];
      end
      if (cmd.clr_idx) idx_r <= '0;
      if (cmd.load) begin
        act_r <= lsrq_pkg::action_t'(in_word.action);
        slot_r <= in_word.task_id;
        range_r <= 1'b1;
        ok_r <= 1'b0;
        sw_r <= 1'b0;
        alloc_r <= '0;
        if (in_word.action == lsrq_pkg::ACT_ACTIVATE && in_word.req_prio != 8'd0)
          prio_r[in_word.task_id] <= in_word.req_prio;
        if (in_word.action == lsrq_pkg::ACT_ACTIVATE && in_word.req_level != 4'd0 &&
            in_word.req_level != level_r[in_word.task_id]) begin
          up_r <= in_word.req_level > level_r[in_word.task_id];
          dn_r <= in_word.req_level < level_r[in_word.task_id];
          level_r[in_word.task_id] <= in_word.req_level;
          lvl_r <= in_word.req_level;
        end else begin
          up_r <= 1'b0;
          dn_r <= 1'b0;
          lvl_r <= level_r[in_word.task_id];
        end
      end
      if (cmd.inc_idx) idx_r <= idx_p1;
      if (cmd.set_idx_len) idx_r <= len_r[IW-1:0];
      if (cmd.alloc_take) begin
        flag_r[idx_r] <= lsrq_pkg::FlagUsed;
        prio_r[idx_r] <= def_prio_r;
        level_r[idx_r] <= def_lvl_r;
        alloc_r <= idx_r;
        ok_r <= 1'b1;
      end
      if (cmd.set_ok) ok_r <= 1'b1;
      if (cmd.mark_used) flag_r[slot_r] <= lsrq_pkg::FlagUsed;
      if (cmd.shift_up) begin
        order_r[idx_r] <= order_r[idx_m1];
        idx_r <= idx_m1;
      end
      if (cmd.shift_dn || cmd.del_shift) begin
        order_r[idx_r] <= order_r[idx_p1];
        idx_r <= idx_p1;
      end
      if (cmd.put_slot) order_r[idx_r] <= slot_r;
      if (cmd.ins_put) begin
        order_r[idx_r] <= slot_r;
        flag_r[slot_r] <= lsrq_pkg::FlagActive;
        len_r <= len_r + CW'(1);
        if ({1'b0, cursor_r} >= idx_w && {1'b0, cursor_r} < len_r) cursor_r <= cursor_r + IW'(1);
      end
      if (cmd.del_done) begin
        len_r <= len_r - CW'(1);
        if (cursor_r >= slot_pos_r && cursor_r != '0) cursor_r <= cursor_r - IW'(1);
      end
      if (cmd.set_cursor) cursor_r <= idx_r;
      if (cmd.do_switch && len_r > CW'(1)) begin
        cursor_r <= nxt_cur;
        if (order_r[nxt_cur] != run_r) begin
          run_r <= order_r[nxt_cur];
          sw_r <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) slot_pos_r <= '0;
    else if (act_r == lsrq_pkg::ACT_DEACT && sts.order_hit && !sts.idx_end && !cmd.del_shift
             && !cmd.del_done)
      slot_pos_r <= idx_r;
  end

  always_comb begin
    if (({1'b0, cursor_r} + CW'(1)) >= len_r) nxt_cur = '0;
    else nxt_cur = cursor_r + IW'(1);
  end

  // The result is read straight from the state registers, which hold still
  // while the word waits in the done state.
  always_comb begin
    out_word.allocated_id = alloc_r;
    out_word.ok = ok_r;
    out_word.switched = sw_r;
    out_word.current_task = run_r;
    out_word.current_priority = prio_r[run_r];
    out_word.running_count = len_r;
  end
endmodule

@@ sv/level_sorted_run_queue.sv @@
// Top level of the level-sorted run queue: controller plus datapath.
// Depends on lsrq_pkg, lsrq_ctrl and lsrq_dp.
//
// A scheduler table of 16 task slots with an ordered run list sorted by
// descending level (ties keep arrival order). Each input word carries one
// action (allocate, activate/update, deactivate, switch) and yields exactly
// one result word. Words are handled one at a time: each word passes through
// decode, then those of the allocate search, the list search, the shift walk
// and the cursor correction pass that its action needs, then the result
// state, which holds until out_ready, and back to idle. The user must write
// the default priority and level registers through the cfg port only while
// the block is idle; the block itself does not enforce this.
module level_sorted_run_queue (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_ready,
  input  lsrq_pkg::in_word_t  in_data,
  output logic                out_valid,
  input  logic                out_ready,
  output lsrq_pkg::out_word_t out_data,
  input  logic                cfg_we,
  input  logic                cfg_index,
  input  logic [7:0]          cfg_wdata
);
  lsrq_pkg::cmd_t cmd;
  lsrq_pkg::sts_t sts;

  lsrq_ctrl u_ctrl (
    .clk(clk), .rst_n(rst_n), .in_valid(in_valid), .in_ready(in_ready),
    .out_valid(out_valid), .out_ready(out_ready), .sts(sts), .cmd(cmd)
  );

  lsrq_dp u_dp (
    .clk(clk), .rst_n(rst_n), .in_word(in_data), .cfg_we(cfg_we),
    .cfg_sel(cfg_index), .cfg_hit(1'b1), .cfg_wdata(cfg_wdata),
    .cmd(cmd), .sts(sts), .out_word(out_data)
  );
endmodule

@@ sv/lsrq_checker.sv @@
// Port-level checker for the run queue, bound to the top level.
// Depends on lsrq_pkg.
module lsrq_checker (
  input logic               clk,
  input logic               rst_n,
  input logic               in_valid,
  input logic               in_ready,
  input logic               out_valid,
  input logic               out_ready,
  input lsrq_pkg::out_word_t out_data
);
  a_no_overlap: assert property (@(posedge clk) disable iff (!rst_n)
    !(in_ready && out_valid)) else $error("input taken while result pending");
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_data))
    else $error("result changed while stalled");
  a_count: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_data.running_count <= 5'd16) else $error("count too large");
  a_sw_ok: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> !(out_data.switched && out_data.ok)) else $error("switch with ok");
endmodule

bind level_sorted_run_queue lsrq_checker u_chk (
  .clk(clk), .rst_n(rst_n), .in_valid(in_valid), .in_ready(in_ready),
  .out_valid(out_valid), .out_ready(out_ready), .out_data(out_data)
);
